// ----- src/sbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsm_pkg: shared types and constants of the serial bank switch mapper
// Bus command codes, result targets, register indexes, reset values and the
// control/status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Bus command carried in the low bits of in_tdata.
  typedef enum logic [1:0] {
    CMD_CPU_READ   = 2'd0,
    CMD_CPU_WRITE  = 2'd1,
    CMD_CHR_ACCESS = 2'd2,
    CMD_SOFT_RESET = 2'd3
  } cmd_t;

  // Memory that serves an access.
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_WRAM = 2'd1,
    TGT_PRG  = 2'd2,
    TGT_CHR  = 2'd3
  } target_t;

  // Configuration register indexes.
  localparam logic REG_PRG_BANK_COUNT  = 1'b0;
  localparam logic REG_CHR_ROM_PRESENT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int MAP_W      = 18;

  localparam logic [4:0] CTRL_RESET      = 5'h1C;
  localparam logic [4:0] CTRL_PRG_16K    = 5'h0C;
  localparam logic [4:0] CHR_WHOLE_MASK  = 5'h1E;
  localparam logic [4:0] PRG_COUNT_RESET = 5'd8;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic             pad;
    logic [1:0]       mirror_mode;
    logic [7:0]       read_data;
    logic [MAP_W-1:0] mapped_address;
    target_t          target;
    logic             claimed;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic load_out;
    logic load_ram_out;
    logic clr_en;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic ram_read;
    logic soft_reset;
    logic clear_last;
  } dp_stat_t;

endpackage

// ----- src/sbsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbsm_ctrl: sequencing controller of the serial bank switch mapper
// Runs the work RAM clearing sweep, the wait state of a work RAM read and the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module sbsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sbsm_pkg::dp_stat_t  stat,
  output sbsm_pkg::ctrl_cmd_t cmd
);
  import sbsm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_RUN,
    S_RAM_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_RUN) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.accept       = in_tvalid && in_tready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.accept) begin
          if (stat.soft_reset) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (stat.ram_read) begin
            state_nxt = S_RAM_WAIT;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      S_RAM_WAIT: begin
        cmd.load_ram_out = 1'b1;
        state_nxt        = S_RUN;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (cmd.load_out || cmd.load_ram_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/sbsm_datapath.sv -----
// ----------------------------------------------------------------------------
// sbsm_datapath: bank registers, serial loader, work RAM and result register
// Decodes each bus access, maps it into program or character memory and
// keeps the mapper state.
// ----------------------------------------------------------------------------
module sbsm_datapath #(
  parameter int RAM_DEPTH = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sbsm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           cfg_we,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  sbsm_pkg::ctrl_cmd_t            cmd,
  output sbsm_pkg::dp_stat_t             stat,
  output logic [sbsm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sbsm_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);

  cmd_t        in_cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        ram_win;
  logic [AW-1:0] ram_off;

  logic [7:0]    ram_mem [RAM_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] raddr_r;
  logic [AW-1:0] clr_cnt_r;
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [7:0]    ram_wd;

  logic [4:0] prg_count_r;
  logic       chr_present_r;
  logic [4:0] shift_r, shift_nxt;
  logic [2:0] count_r, count_nxt;
  logic [4:0] ctrl_r, ctrl_nxt;
  logic [4:0] chr_lo_r, chr_lo_nxt;
  logic [4:0] chr_hi_r, chr_hi_nxt;
  logic [4:0] chr_whole_r, chr_whole_nxt;
  logic [2:0] prg_whole_r, prg_whole_nxt;
  logic [3:0] prg_lo_r, prg_lo_nxt;
  logic [3:0] prg_hi_r, prg_hi_nxt;
  logic [1:0] mirror_r, mirror_nxt;

  logic [3:0] last_bank;
  logic [4:0] shift_in;
  logic [3:0] prg_bank;
  logic [4:0] chr_bank;
  result_t    res;
  result_t    ram_res;
  result_t    out_r;

  assign in_cmd  = cmd_t'(in_tdata[1:0]);
  assign addr    = in_tdata[17:2];
  assign wdata   = in_tdata[25:18];
  assign ram_win = (in_cmd == CMD_CPU_READ || in_cmd == CMD_CPU_WRITE)
                   && (addr[15:13] == 3'b011);
  assign ram_off = addr[AW-1:0];
  assign last_bank = prg_count_r[3:0] - 4'd1;
  assign shift_in  = {wdata[0], shift_r[4:1]};
  assign prg_bank  = addr[14] ? prg_hi_r : prg_lo_r;
  assign chr_bank  = addr[12] ? chr_hi_r : chr_lo_r;

  assign stat.ram_read   = ram_win && (in_cmd == CMD_CPU_READ);
  assign stat.soft_reset = (in_cmd == CMD_SOFT_RESET);
  assign stat.clear_last = (clr_cnt_r == {AW{1'b1}});

  always_comb begin
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    ctrl_nxt      = ctrl_r;
    chr_lo_nxt    = chr_lo_r;
    chr_hi_nxt    = chr_hi_r;
    chr_whole_nxt = chr_whole_r;
    prg_whole_nxt = prg_whole_r;
    prg_lo_nxt    = prg_lo_r;
    prg_hi_nxt    = prg_hi_r;
    mirror_nxt    = mirror_r;
    res           = '0;
    case (in_cmd)
      CMD_CPU_READ, CMD_CPU_WRITE: begin
        if (ram_win) begin
          res.claimed        = 1'b1;
          res.target         = TGT_WRAM;
          res.mapped_address = MAP_W'(ram_off);
        end else if (addr[15]) begin
          if (in_cmd == CMD_CPU_READ) begin
            res.claimed = 1'b1;
            res.target  = TGT_PRG;
            if (ctrl_r[3]) begin
              res.mapped_address = {prg_bank, addr[13:0]};
            end else begin
              res.mapped_address = {prg_whole_r, addr[14:0]};
            end
          end else if (wdata[7]) begin
            shift_nxt = '0;
            count_nxt = '0;
            ctrl_nxt  = ctrl_r | CTRL_PRG_16K;
          end else if (count_r >= 3'd4) begin
            // Fifth bit: the assembled value goes to the register picked by
            // address bits 14:13.
            shift_nxt = '0;
            count_nxt = '0;
            case (addr[14:13])
              2'd0: begin
                ctrl_nxt   = shift_in;
                mirror_nxt = shift_in[1:0];
              end
              2'd1: begin
                if (ctrl_r[4]) begin
                  chr_lo_nxt = shift_in;
                end else begin
                  chr_whole_nxt = shift_in & CHR_WHOLE_MASK;
                end
              end
              2'd2: begin
                if (ctrl_r[4]) begin
                  chr_hi_nxt = shift_in;
                end
              end
              default: begin
                case (ctrl_r[3:2])
                  2'd2: begin
                    prg_lo_nxt = '0;
                    prg_hi_nxt = shift_in[3:0];
                  end
                  2'd3: begin
                    prg_lo_nxt = shift_in[3:0];
                    prg_hi_nxt = last_bank;
                  end
                  default: begin
                    prg_whole_nxt = shift_in[3:1];
                  end
                endcase
              end
            endcase
          end else begin
            shift_nxt = shift_in;
            count_nxt = count_r + 3'd1;
          end
        end
      end
      CMD_CHR_ACCESS: begin
        if (addr[15:13] == 3'b000) begin
          res.claimed = 1'b1;
          res.target  = TGT_CHR;
          if (!chr_present_r) begin
            res.mapped_address = MAP_W'(addr);
          end else if (ctrl_r[4]) begin
            res.mapped_address = {1'b0, chr_bank, addr[11:0]};
          end else begin
            res.mapped_address = {1'b0, chr_whole_r, 12'h000}
                                 + {5'b0, addr[12:0]};
          end
        end
      end
      default: begin
        // Soft reset: bank state back to defaults, mirroring kept.
        shift_nxt     = '0;
        count_nxt     = '0;
        ctrl_nxt      = CTRL_RESET;
        chr_lo_nxt    = '0;
        chr_hi_nxt    = '0;
        chr_whole_nxt = '0;
        prg_whole_nxt = '0;
        prg_lo_nxt    = '0;
        prg_hi_nxt    = last_bank;
      end
    endcase
    res.mirror_mode = mirror_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r   <= PRG_COUNT_RESET;
      chr_present_r <= 1'b1;
      shift_r       <= '0;
      count_r       <= '0;
      ctrl_r        <= CTRL_RESET;
      chr_lo_r      <= '0;
      chr_hi_r      <= '0;
      chr_whole_r   <= '0;
      prg_whole_r   <= '0;
      prg_lo_r      <= '0;
      prg_hi_r      <= PRG_COUNT_RESET[3:0] - 4'd1;
      mirror_r      <= '0;
      clr_cnt_r     <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_PRG_BANK_COUNT) begin
        prg_count_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_CHR_ROM_PRESENT) begin
        chr_present_r <= cfg_wdata[0];
      end
      if (cmd.accept) begin
        shift_r     <= shift_nxt;
        count_r     <= count_nxt;
        ctrl_r      <= ctrl_nxt;
        chr_lo_r    <= chr_lo_nxt;
        chr_hi_r    <= chr_hi_nxt;
        chr_whole_r <= chr_whole_nxt;
        prg_whole_r <= prg_whole_nxt;
        prg_lo_r    <= prg_lo_nxt;
        prg_hi_r    <= prg_hi_nxt;
        mirror_r    <= mirror_nxt;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Work RAM: one write port shared by the clearing sweep and CPU writes.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = ram_off;
    ram_wd = wdata;
    if (cmd.clr_en) begin
      ram_we = 1'b1;
      ram_wa = clr_cnt_r;
      ram_wd = '0;
    end else if (cmd.accept && ram_win && in_cmd == CMD_CPU_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_wa] <= ram_wd;
    end
    if (cmd.accept) begin
      rd_q    <= ram_mem[ram_off];
      raddr_r <= ram_off;
    end
  end

  // Result of a work RAM read, built from the registered read port.
  always_comb begin
    ram_res                = '0;
    ram_res.claimed        = 1'b1;
    ram_res.target         = TGT_WRAM;
    ram_res.mapped_address = MAP_W'(raddr_r);
    ram_res.read_data      = rd_q;
    ram_res.mirror_mode    = mirror_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res;
    end else if (cmd.load_ram_out) begin
      out_r <= ram_res;
    end
  end

  assign out_tdata = out_r;

endmodule

// ----- src/serial_bank_switch_mapper_core.sv -----
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core: cartridge bank mapper with serial loading
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Each bus access arrives as one input transfer and produces exactly one result
// transfer. Right after reset, and again after every soft reset command, the
// block sweeps the work RAM to zero one byte per cycle; in_tready stays low during
// the sweep while configuration writes are still taken. Outside the sweep, program
// ROM reads, character accesses, register writes and work RAM writes allow one
// transfer to be accepted every cycle while the output register is free or its
// result is being taken. A work RAM read passes through a wait state, with no
// transfer accepted meanwhile, because the RAM read port is registered. Results
// sit in an output register, and a new transfer is accepted in the same cycle
// that the waiting result is taken. Configuration (bank count, character ROM
// present) should only be written while no transfer is in flight.
module serial_bank_switch_mapper_core #(
  parameter int RAM_DEPTH = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: command[1:0], address[17:2], write_data[25:18], zeros.
  input  logic [sbsm_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: claimed[0], target[2:1], mapped_address[20:3],
  // read_data[28:21], mirror_mode[30:29], zero.
  output logic [sbsm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbsm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sbsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sbsm_datapath #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

  // No input transfer is taken while the RAM sweep runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_tready)
    else $error("input accepted during work RAM clearing");

  // A soft reset starts the clearing sweep in the next cycle.
  a_soft_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && stat.soft_reset) |=> cmd.clr_en)
    else $error("soft reset did not start the clearing sweep");

  // A work RAM read loads its result in the cycle after it was accepted.
  a_ram_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && stat.ram_read) |=> cmd.load_ram_out)
    else $error("work RAM read result not loaded");

  // The RAM read result never overwrites a result still waiting.
  a_ram_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ram_out |-> !out_tvalid)
    else $error("RAM read result overwrote a pending result");

endmodule
